[hdl/pel_pkg.sv]
// shared types, constants and helper functions for the particle euler update block
// no dependencies
package pel_pkg;

    localparam int FRAC_BITS = 16;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint C05_Q = (ONE_Q * 5 + 50) / 100;
    localparam longint C08_Q = (ONE_Q * 4 + 2) / 5;
    localparam logic signed [31:0] GRAV_RESET = 32'(-(15 * ONE_Q));
    localparam logic [31:0] STEP_RESET = 32'(ONE_Q / 60);

    localparam int RATIO_W = FRAC_BITS + 1;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(ONE_Q);
    localparam int DIV_ST = (FRAC_BITS + 1) / 2;

    localparam int CORD_STEPS = 30;
    localparam int CORD_ST = CORD_STEPS / 2;
    localparam int Q30_SH = 30 - FRAC_BITS;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        age;
        logic [31:0]        lifetime;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] gravity;
        logic [31:0]        step;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] nvy;
        logic [31:0]        nage;
        logic [31:0]        life;
    } t_kin;

    typedef struct packed {
        logic signed [31:0]  nx;
        logic signed [31:0]  ny;
        logic signed [31:0]  nz;
        logic signed [31:0]  nvy;
        logic [31:0]         nage;
        logic [RATIO_W-1:0]  ratio;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // arctangent of 2^-i in q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h3243F6A8;
            5'd1:  return 32'h1DAC6705;
            5'd2:  return 32'h0FADBAFC;
            5'd3:  return 32'h07F56EA6;
            5'd4:  return 32'h03FEAB76;
            5'd5:  return 32'h01FFD55B;
            5'd6:  return 32'h00FFFAAA;
            5'd7:  return 32'h007FFF55;
            5'd8:  return 32'h003FFFEA;
            5'd9:  return 32'h001FFFFD;
            5'd10: return 32'h000FFFFF;
            5'd11: return 32'h0007FFFF;
            5'd12: return 32'h0003FFFF;
            5'd13: return 32'h0001FFFF;
            5'd14: return 32'h0000FFFF;
            5'd15: return 32'h00007FFF;
            5'd16: return 32'h00003FFF;
            5'd17: return 32'h00001FFF;
            5'd18: return 32'h00000FFF;
            5'd19: return 32'h000007FF;
            5'd20: return 32'h000003FF;
            5'd21: return 32'h000001FF;
            5'd22: return 32'h000000FF;
            5'd23: return 32'h0000007F;
            5'd24: return 32'h0000003F;
            5'd25: return 32'h0000001F;
            5'd26: return 32'h0000000F;
            5'd27: return 32'h00000007;
            5'd28: return 32'h00000003;
            5'd29: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

[hdl/pel_kin.sv]
// four-stage kinematics pipeline: age, velocity and position update
// depends on pel_pkg
module pel_kin
    import pel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_particle i_item,
    input  t_cfg      i_cfg,
    output logic      o_vld,
    output t_kin      o_kin
);

    logic [3:0] r_vld;

    logic signed [64:0] n_step;
    logic [32:0]        n_s1_age;
    logic signed [64:0] n_s1_pgy, n_s1_pvx, n_s1_pvz;

    logic [31:0]        r_s1_nage, r_s1_life;
    logic signed [64:0] r_s1_pgy, r_s1_pvx, r_s1_pvz;
    logic signed [31:0] r_s1_px, r_s1_py, r_s1_pz, r_s1_vy;

    logic signed [31:0] r_s2_nvy, r_s2_nx, r_s2_nz, r_s2_px, r_s2_py, r_s2_pz;
    logic [31:0]        r_s2_nage, r_s2_life;

    logic signed [64:0] r_s3_pny;
    logic signed [31:0] r_s3_nvy, r_s3_nx, r_s3_nz, r_s3_px, r_s3_py, r_s3_pz;
    logic [31:0]        r_s3_nage, r_s3_life;

    t_kin r_s4_kin;
    t_kin n_s4_kin;

    assign n_step   = 65'($signed({1'b0, i_cfg.step}));
    assign n_s1_age = {1'b0, i_item.age} + {1'b0, i_cfg.step};
    assign n_s1_pgy = 65'(i_cfg.gravity) * n_step;
    assign n_s1_pvx = 65'(i_item.vel_x) * n_step;
    assign n_s1_pvz = 65'(i_item.vel_z) * n_step;

    always_comb begin
        n_s4_kin.nvy  = r_s3_nvy;
        n_s4_kin.nage = r_s3_nage;
        n_s4_kin.life = r_s3_life;
        if (r_s3_py <= 0) begin
            n_s4_kin.nx = r_s3_px;
            n_s4_kin.ny = '0;
            n_s4_kin.nz = r_s3_pz;
        end else begin
            n_s4_kin.nx = r_s3_nx;
            n_s4_kin.ny = sat32(66'(r_s3_py) + 66'(r_s3_pny >>> FRAC_BITS));
            n_s4_kin.nz = r_s3_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_nage <= n_s1_age[32] ? 32'hFFFFFFFF : n_s1_age[31:0];
            r_s1_life <= i_item.lifetime;
            r_s1_pgy  <= n_s1_pgy;
            r_s1_pvx  <= n_s1_pvx;
            r_s1_pvz  <= n_s1_pvz;
            r_s1_px   <= i_item.pos_x;
            r_s1_py   <= i_item.pos_y;
            r_s1_pz   <= i_item.pos_z;
            r_s1_vy   <= i_item.vel_y;

            r_s2_nvy  <= sat32(66'(r_s1_vy) + 66'(r_s1_pgy >>> FRAC_BITS));
            r_s2_nx   <= sat32(66'(r_s1_px) + 66'(r_s1_pvx >>> FRAC_BITS));
            r_s2_nz   <= sat32(66'(r_s1_pz) + 66'(r_s1_pvz >>> FRAC_BITS));
            r_s2_px   <= r_s1_px;
            r_s2_py   <= r_s1_py;
            r_s2_pz   <= r_s1_pz;
            r_s2_nage <= r_s1_nage;
            r_s2_life <= r_s1_life;

            r_s3_pny  <= 65'(r_s2_nvy) * n_step;
            r_s3_nvy  <= r_s2_nvy;
            r_s3_nx   <= r_s2_nx;
            r_s3_nz   <= r_s2_nz;
            r_s3_px   <= r_s2_px;
            r_s3_py   <= r_s2_py;
            r_s3_pz   <= r_s2_pz;
            r_s3_nage <= r_s2_nage;
            r_s3_life <= r_s2_life;

            r_s4_kin  <= n_s4_kin;
        end
    end

    assign o_vld = r_vld[3];
    assign o_kin = r_s4_kin;

endmodule

[hdl/pel_div.sv]
// pipelined restoring divider for the life ratio, two quotient bits per stage
// depends on pel_pkg
module pel_div
    import pel_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_kin  i_kin,
    output logic  o_vld,
    output t_side o_side
);

    typedef struct packed {
        logic [31:0]          rem;
        logic [FRAC_BITS-1:0] quo;
    } t_dstate;

    logic [DIV_ST:0] r_vld;
    t_kin            r_kin  [0:DIV_ST];
    t_dstate         r_st   [0:DIV_ST];
    logic            r_full [0:DIV_ST];

    function automatic t_dstate div2(input t_dstate st, input logic [31:0] d, input int base);
        t_dstate     res;
        logic [32:0] rem2;
        res  = st;
        rem2 = '0;
        for (int t = 0; t < 2; t++) begin
            if (base + t < FRAC_BITS) begin
                rem2 = {res.rem, 1'b0};
                if (rem2 >= {1'b0, d}) begin
                    rem2    = rem2 - {1'b0, d};
                    res.quo = {res.quo[FRAC_BITS-2:0], 1'b1};
                end else begin
                    res.quo = {res.quo[FRAC_BITS-2:0], 1'b0};
                end
                res.rem = rem2[31:0];
            end
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_ST-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kin[0]    <= i_kin;
            r_st[0].rem <= i_kin.nage;
            r_st[0].quo <= '0;
            r_full[0]   <= (i_kin.life == '0) || (i_kin.nage >= i_kin.life);
            for (int s = 1; s <= DIV_ST; s++) begin
                r_kin[s]  <= r_kin[s-1];
                r_st[s]   <= div2(r_st[s-1], r_kin[s-1].life, 2 * (s - 1));
                r_full[s] <= r_full[s-1];
            end
        end
    end

    always_comb begin
        o_side.nx    = r_kin[DIV_ST].nx;
        o_side.ny    = r_kin[DIV_ST].ny;
        o_side.nz    = r_kin[DIV_ST].nz;
        o_side.nvy   = r_kin[DIV_ST].nvy;
        o_side.nage  = r_kin[DIV_ST].nage;
        o_side.ratio = r_full[DIV_ST] ? RATIO_ONE : {1'b0, r_st[DIV_ST].quo};
    end

    assign o_vld = r_vld[DIV_ST];

endmodule

[hdl/pel_cordic.sv]
// pipelined vectoring cordic for the horizontal direction angle
// two normalize stages, then two micro-rotations per stage; depends on pel_pkg
module pel_cordic
    import pel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_side              i_side,
    output logic               o_vld,
    output t_side              o_side,
    output logic signed [33:0] o_acc,
    output logic               o_zero
);

    localparam int LAST = CORD_ST + 2;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] acc;
    } t_cstate;

    logic [LAST:0] r_vld;
    t_side         r_side [0:LAST];
    t_cstate       r_st   [0:LAST];
    logic          r_zero [0:LAST];

    function automatic logic signed [35:0] absv(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w < 0) begin
            w = -w;
        end
        return 36'($unsigned(w));
    endfunction

    function automatic t_cstate norm(input t_cstate c, input int k);
        t_cstate     res;
        logic [31:0] o;
        res = c;
        o   = c.x[31:0] | c.y[31:0];
        if ((o >> (31 - k)) == '0) begin
            res.x = c.x <<< k;
            res.y = c.y <<< k;
        end
        return res;
    endfunction

    function automatic t_cstate cstep(input t_cstate c, input int i);
        t_cstate            res;
        logic signed [35:0] xs, ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (c.y > 0) begin
            res.x   = c.x + ys;
            res.y   = c.y - xs;
            res.acc = c.acc + 34'(atan_q30(5'(i)));
        end else begin
            res.x   = c.x - ys;
            res.y   = c.y + xs;
            res.acc = c.acc - 34'(atan_q30(5'(i)));
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAST-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]    <= i_side;
            r_st[0].x    <= absv(i_side.nx);
            r_st[0].y    <= absv(i_side.nz);
            r_st[0].acc  <= '0;
            r_zero[0]    <= (i_side.nx == '0) && (i_side.nz == '0);

            r_side[1]    <= r_side[0];
            r_st[1]      <= norm(norm(r_st[0], 16), 8);
            r_zero[1]    <= r_zero[0];

            r_side[2]    <= r_side[1];
            r_st[2]      <= norm(norm(norm(r_st[1], 4), 2), 1);
            r_zero[2]    <= r_zero[1];

            for (int s = 3; s <= LAST; s++) begin
                r_side[s] <= r_side[s-1];
                r_st[s]   <= cstep(cstep(r_st[s-1], 2 * (s - 3)), 2 * (s - 3) + 1);
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    assign o_vld  = r_vld[LAST];
    assign o_side = r_side[LAST];
    assign o_acc  = r_st[LAST].acc;
    assign o_zero = r_zero[LAST];

endmodule

[hdl/particle_euler_update.sv]
// particle euler update, top level: config registers, output stage, pipeline chain
// one particle per cycle sustained while the output is not stalled; a request passes
// through the 4 kinematics, 9 divider and 18 cordic stages plus the output register
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// synchronous active-low reset clears valid bits and restores gravity -15.0 and step 1/60
// depends on pel_pkg, pel_kin, pel_div, pel_cordic
module particle_euler_update
    import pel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic signed [31:0]   i_vel_x,
    input  logic signed [31:0]   i_vel_y,
    input  logic signed [31:0]   i_vel_z,
    input  logic [31:0]          i_age,
    input  logic [31:0]          i_lifetime,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_new_pos_x,
    output logic signed [31:0]   o_new_pos_y,
    output logic signed [31:0]   o_new_pos_z,
    output logic signed [31:0]   o_new_vel_y,
    output logic [31:0]          o_new_age,
    output logic [17:0]          o_color_red,
    output logic signed [31:0]   o_color_green,
    output logic signed [17:0]   o_color_blue,
    output logic [25:0]          o_spin_angle,
    output logic [15:0]          o_quad_size,
    output logic                 o_grounded
);

    localparam logic [32:0] HALF_LSB = 33'(1) << (Q30_SH - 1);

    logic                 r_out_vld;
    t_cfg                 r_cfg;
    logic                 n_en;
    t_particle            n_item;

    logic                 kin_vld, div_vld, cor_vld;
    t_kin                 kin_out;
    t_side                div_side, cor_side;
    logic signed [33:0]   cor_acc;
    logic                 cor_zero;

    logic [30:0]          n_ang;
    logic [31:0]          n_ang_red;
    logic [32:0]          n_red_q, n_blue_q;
    logic signed [63:0]   n_green;
    logic [39:0]          n_spin, n_quad;
    logic [17:0]          n_red, n_blue;

    logic signed [31:0]   r_pos_x, r_pos_y, r_pos_z, r_vel_y, r_green;
    logic [31:0]          r_age;
    logic [17:0]          r_red, r_blue;
    logic [25:0]          r_spin;
    logic [15:0]          r_quad;
    logic                 r_ground;

    assign n_en        = !r_out_vld || i_out_ready;
    assign o_in_ready  = n_en;
    assign o_cfg_ready = 1'b1;

    assign n_item.pos_x    = i_pos_x;
    assign n_item.pos_y    = i_pos_y;
    assign n_item.pos_z    = i_pos_z;
    assign n_item.vel_x    = i_vel_x;
    assign n_item.vel_y    = i_vel_y;
    assign n_item.vel_z    = i_vel_z;
    assign n_item.age      = i_age;
    assign n_item.lifetime = i_lifetime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity <= GRAV_RESET;
            r_cfg.step    <= STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRAVITY: r_cfg.gravity <= i_cfg_data;
                CFG_STEP:    r_cfg.step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pel_kin u_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (i_in_valid),
        .i_item  (n_item),
        .i_cfg   (r_cfg),
        .o_vld   (kin_vld),
        .o_kin   (kin_out)
    );

    pel_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (kin_vld),
        .i_kin   (kin_out),
        .o_vld   (div_vld),
        .o_side  (div_side)
    );

    pel_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (div_vld),
        .i_side  (div_side),
        .o_vld   (cor_vld),
        .o_side  (cor_side),
        .o_acc   (cor_acc),
        .o_zero  (cor_zero)
    );

    // angle clamp, q2.30 to q.f rounding, color and size terms
    always_comb begin
        if (cor_acc < 0) begin
            n_ang = '0;
        end else if (cor_acc > 34'(HALF_PI_Q30)) begin
            n_ang = HALF_PI_Q30;
        end else begin
            n_ang = cor_acc[30:0];
        end
        n_ang_red = (cor_side.nx < 0) ? (PI_Q30 - {1'b0, n_ang}) : {1'b0, n_ang};
        n_red_q   = (33'(n_ang_red) + HALF_LSB) >> Q30_SH;
        n_blue_q  = (33'(n_ang) + HALF_LSB) >> Q30_SH;
        if (cor_zero) begin
            n_red  = '0;
            n_blue = '0;
        end else begin
            n_red  = n_red_q[17:0];
            n_blue = (cor_side.nz < 0) ? (18'd0 - n_blue_q[17:0]) : n_blue_q[17:0];
        end
        n_green = (64'(cor_side.ny) * 64'(C05_Q)) >>> FRAC_BITS;
        n_spin  = 40'(cor_side.ratio) * 40'd720;
        n_quad  = (40'(C08_Q) * 40'(RATIO_ONE - cor_side.ratio)) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_en) begin
            r_out_vld <= cor_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_pos_x  <= cor_side.nx;
            r_pos_y  <= cor_side.ny;
            r_pos_z  <= cor_side.nz;
            r_vel_y  <= cor_side.nvy;
            r_age    <= cor_side.nage;
            r_red    <= n_red;
            r_green  <= n_green[31:0];
            r_blue   <= n_blue;
            r_spin   <= n_spin[25:0];
            r_quad   <= n_quad[15:0];
            r_ground <= (cor_side.ny <= 0);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_new_pos_x   = r_pos_x;
    assign o_new_pos_y   = r_pos_y;
    assign o_new_pos_z   = r_pos_z;
    assign o_new_vel_y   = r_vel_y;
    assign o_new_age     = r_age;
    assign o_color_red   = r_red;
    assign o_color_green = r_green;
    assign o_color_blue  = r_blue;
    assign o_spin_angle  = r_spin;
    assign o_quad_size   = r_quad;
    assign o_grounded    = r_ground;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");
    a_grounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_grounded == (o_new_pos_y <= 0)))
        else $error("grounded flag disagrees with height");
    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_pos_x == 0 && o_new_pos_z == 0)
            |-> (o_color_red == 0 && o_color_blue == 0))
        else $error("color nonzero at zero horizontal length");
`endif

endmodule
